### src/kpblink_pkg.sv
// ----------------------------------------------------------------------------
// kpblink_pkg: shared types and constants for the keypad blinker
// Widths, reset values, register indexes, sequencer states and the control
// bundle that the sequencer hands to the serial scan and divide units.
// ----------------------------------------------------------------------------
package kpblink_pkg;

	localparam int KEYS_W     = 16;
	localparam int CODE_W     = 5;
	localparam int RATE_W     = 5;
	localparam int DEB_W      = 8;
	localparam int TPS_W      = 16;
	localparam int PHASE_W    = 15;
	localparam int STEP_W     = 4;
	localparam int DIVISOR_W  = RATE_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam int KEY_ROWS_DEF = 4;
	localparam int KEY_COLS_DEF = 4;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd7;
	localparam logic [TPS_W-1:0]  TPS_RESET      = 16'd1000;
	localparam logic [RATE_W-1:0] RATE_RESET     = 5'd1;
	localparam logic [STEP_W-1:0] STEP_LAST      = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TICKS   = 1'b0,
		REG_TICKS_PER_SECOND = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COMMIT
	} seq_state_t;

	// control from the sequencer to the serial units
	typedef struct packed {
		logic              start;
		logic              step;
		logic [STEP_W-1:0] idx;
	} ctl_t;

endpackage

### src/kpblink_scan.sv
// ----------------------------------------------------------------------------
// kpblink_scan: bit-serial key matrix scanner
// Shifts the key snapshot out one switch per cycle and keeps the code of the
// first closed switch in row-major order, zero when none is closed.
// ----------------------------------------------------------------------------
module kpblink_scan #(
	parameter int KEY_ROWS = kpblink_pkg::KEY_ROWS_DEF,
	parameter int KEY_COLS = kpblink_pkg::KEY_COLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kpblink_pkg::ctl_t                 ctl,
	input  logic [kpblink_pkg::KEYS_W-1:0]    keys,
	output logic [kpblink_pkg::CODE_W-1:0]    code
);
	import kpblink_pkg::*;

	// switches past the matrix or past the field are ignored
	localparam int MATRIX_BITS = KEY_ROWS * KEY_COLS;
	localparam int SCAN_BITS   = (MATRIX_BITS < KEYS_W) ? MATRIX_BITS : KEYS_W;
	localparam logic [CODE_W-1:0] SCAN_LIMIT = CODE_W'(SCAN_BITS);

	logic [KEYS_W-1:0] keys_q;
	logic [CODE_W-1:0] code_q;
	logic [CODE_W-1:0] pos;

	assign pos = {1'b0, ctl.idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
		end else if (ctl.start) begin
			code_q <= '0;
		end else if (ctl.step) begin
			if (code_q == '0 && keys_q[0] && pos < SCAN_LIMIT) begin
				code_q <= pos + CODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			keys_q <= keys;
		end else if (ctl.step) begin
			keys_q <= keys_q >> 1;
		end
	end

	assign code = code_q;

endmodule

### src/kpblink_div.sv
// ----------------------------------------------------------------------------
// kpblink_div: bit-serial restoring divider for the half blink period
// Divides ticks_per_second by twice the rate, one quotient bit per cycle,
// sixteen steps from the most significant dividend bit down.
// ----------------------------------------------------------------------------
module kpblink_div (
	input  logic                               clk,
	input  kpblink_pkg::ctl_t                  ctl,
	input  logic [kpblink_pkg::TPS_W-1:0]      dividend,
	input  logic [kpblink_pkg::RATE_W-1:0]     rate,
	output logic [kpblink_pkg::TPS_W-1:0]      quotient
);
	import kpblink_pkg::*;

	logic [TPS_W-1:0]     dvd_q;
	logic [RATE_W-1:0]    rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W-1:0] trial;
	logic [DIVISOR_W-1:0] diff;
	logic                 fits;

	// remainder stays below the divisor, which is at most 32
	assign trial = {rem_q, dvd_q[TPS_W-1]};
	assign fits  = trial >= dsr_q;
	assign diff  = trial - dsr_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= {rate, 1'b0};
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[TPS_W-2:0], fits};
			rem_q <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign quotient = dvd_q;

endmodule

### src/keypad_rate_select_led_blinker_core.sv
// ----------------------------------------------------------------------------
// keypad_rate_select_led_blinker_core: keypad rate select and LED blinker
// Sequence: an input transfer starts sixteen serial steps of the scan and of the
// bit-serial half-period divider, then a commit state registers the result.
// Flow: one item at a time (accept, 16 steps, commit); a result waiting in the
// output register does not block the next accept, only the next commit.
// Reset: asynchronous, active low; rate 1, LED off, debounce 7, 1000 ticks.
// ----------------------------------------------------------------------------
module keypad_rate_select_led_blinker_core #(
	parameter int KEY_ROWS = kpblink_pkg::KEY_ROWS_DEF,
	parameter int KEY_COLS = kpblink_pkg::KEY_COLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// keys_down[15:0]
	input  logic [kpblink_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// scancode[4:0], blink_rate[9:5], blue_led[10], green_led[11], zero[15:12]
	output logic [kpblink_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic                                  cfg_we,
	input  logic [kpblink_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [kpblink_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import kpblink_pkg::*;

	seq_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	ctl_t ctl;
	logic commit;

	logic [DEB_W-1:0]   debounce_q;
	logic [TPS_W-1:0]   tps_q;
	logic               blink_q;
	logic [PHASE_W-1:0] phase_q;
	logic [RATE_W-1:0]  rate_q;
	logic [DEB_W-1:0]   holdoff_q;
	logic               key_held_q;

	logic [CODE_W-1:0] code;
	logic [TPS_W-1:0]  quotient;

	logic               key_down;
	logic               frozen;
	logic               blink_d;
	logic [PHASE_W-1:0] phase_d;
	logic [RATE_W-1:0]  rate_d;
	logic [DEB_W-1:0]   holdoff_d;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			tps_q      <= TPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_DEBOUNCE_TICKS:   debounce_q <= cfg_wdata[DEB_W-1:0];
				REG_TICKS_PER_SECOND: tps_q      <= cfg_wdata[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_RUN;
			ST_RUN:    if (step_q == STEP_LAST) state_d = ST_COMMIT;
			ST_COMMIT: if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		ctl.start = (state_q == ST_IDLE) && s_tvalid;
		ctl.step  = (state_q == ST_RUN);
		ctl.idx   = step_q;
		commit    = (state_q == ST_COMMIT) && (!m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.start) begin
				step_q <= '0;
			end else if (ctl.step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	kpblink_scan #(
		.KEY_ROWS(KEY_ROWS),
		.KEY_COLS(KEY_COLS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.keys  (s_tdata[KEYS_W-1:0]),
		.code  (code)
	);

	kpblink_div u_div (
		.clk     (clk),
		.ctl     (ctl),
		.dividend(tps_q),
		.rate    (rate_q),
		.quotient(quotient)
	);

	// tick update, applied at commit
	assign key_down = (code != '0);
	assign frozen   = key_held_q && key_down;

	always_comb begin
		blink_d   = blink_q;
		phase_d   = phase_q;
		rate_d    = rate_q;
		holdoff_d = holdoff_q;
		if (!frozen) begin
			if (phase_q == '0) begin
				blink_d = !blink_q;
				// half period below one counts as one, then the tick's decrement
				if (quotient[TPS_W-1:1] == '0) begin
					phase_d = '0;
				end else begin
					phase_d = quotient[PHASE_W-1:0] - PHASE_W'(1);
				end
			end else begin
				phase_d = phase_q - PHASE_W'(1);
			end
			priority if (key_down && holdoff_q == '0) begin
				rate_d    = code;
				holdoff_d = debounce_q;
			end else if (holdoff_q != '0) begin
				holdoff_d = holdoff_q - DEB_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q    <= 1'b0;
			phase_q    <= '0;
			rate_q     <= RATE_RESET;
			holdoff_q  <= '0;
			key_held_q <= 1'b0;
		end else if (commit) begin
			blink_q    <= blink_d;
			phase_q    <= phase_d;
			rate_q     <= rate_d;
			holdoff_q  <= holdoff_d;
			key_held_q <= key_down;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= {4'b0000, key_down, blink_d, rate_d, code};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	ast_commit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_valid_q)
		else $error("commit did not present a result");

	ast_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (step_q != STEP_LAST) |=> (state_q == ST_RUN))
		else $error("serial run ended early");

	ast_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_q != '0) && (rate_q <= RATE_W'(16)))
		else $error("blink rate out of range");

	ast_key_held: assert property (@(posedge clk) disable iff (!arst_n)
		commit && key_down |=> key_held_q)
		else $error("key held flag not set after a press");

	ast_frozen_rate: assert property (@(posedge clk) disable iff (!arst_n)
		commit && frozen |=> $stable(rate_q) && $stable(phase_q))
		else $error("state moved on a frozen tick");

endmodule

### tb/sv/keypad_rate_select_led_blinker_core_test.sv
// ----------------------------------------------------------------------------
// keypad_rate_select_led_blinker_core_test: self-checking bench for the blinker
// Sends key matrix snapshots, one per tick, through the input stream. A tick
// model tracks scan code, rate, debounce and blink phase, and every output
// transfer is checked field by field against it. The run passes through
// several debounce and ticks-per-second settings, with random stalls on both
// streams.
// ----------------------------------------------------------------------------
module keypad_rate_select_led_blinker_core_test;

	import kpblink_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] scancode;
		logic [RATE_W-1:0] blink_rate;
		logic              blue_led;
		logic              green_led;
	} led_result_t;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 80;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// snapshots waiting to be sent and tick results still to arrive
	logic [KEYS_W-1:0] pending_keys[$];
	led_result_t       expected_leds[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;

	// tick model: configuration and state
	logic [DEB_W-1:0]   deb_ticks;
	logic [TPS_W-1:0]   tps_ticks;
	logic               blink_on;
	logic [PHASE_W-1:0] phase_left;
	logic [RATE_W-1:0]  rate_now;
	logic [DEB_W-1:0]   holdoff_left;
	logic               key_held;

	keypad_rate_select_led_blinker_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic [CODE_W-1:0] first_key(logic [KEYS_W-1:0] keys);
		for (int pos = 0; pos < KEY_ROWS_DEF * KEY_COLS_DEF && pos < KEYS_W; pos++) begin
			if (keys[pos])
				return CODE_W'(pos + 1);
		end
		return '0;
	endfunction

	// one tick of the blinker; a key still down after a press freezes the state
	function automatic led_result_t advance_blinker(logic [KEYS_W-1:0] keys);
		logic [CODE_W-1:0] code;
		int unsigned       half;
		led_result_t       res;
		code = first_key(keys);
		if (!(key_held && code != 0)) begin
			key_held = 1'b0;
			if (phase_left == 0) begin
				half = int'(tps_ticks) / (2 * int'(rate_now));
				if (half == 0)
					half = 1;
				blink_on = ~blink_on;
				phase_left = PHASE_W'(half);
			end
			if (phase_left != 0)
				phase_left = phase_left - 1'b1;
			if (code != 0 && holdoff_left == 0) begin
				rate_now = code;
				holdoff_left = deb_ticks;
			end else if (holdoff_left != 0) begin
				holdoff_left = holdoff_left - 1'b1;
			end
			if (code != 0)
				key_held = 1'b1;
		end
		res.scancode = code;
		res.blink_rate = rate_now;
		res.blue_led = blink_on;
		res.green_led = (code != 0);
		return res;
	endfunction

	// input side: hold each snapshot until its transfer, then predict the tick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_leds.push_back(advance_blinker(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_keys.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random backpressure and field checks
	always @(posedge clk or negedge arst_n) begin
		led_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_leds.size() == 0) begin
					$error("unexpected transfer: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_leds.pop_front();
					if (m_tdata[4:0] !== want.scancode) begin
						$error("scancode: expected %0d, got %0d", want.scancode, m_tdata[4:0]);
						fail_count++;
					end
					if (m_tdata[9:5] !== want.blink_rate) begin
						$error("blink_rate: expected %0d, got %0d", want.blink_rate,
							m_tdata[9:5]);
						fail_count++;
					end
					if (m_tdata[10] !== want.blue_led) begin
						$error("blue_led: expected %0d, got %0d", want.blue_led, m_tdata[10]);
						fail_count++;
					end
					if (m_tdata[11] !== want.green_led) begin
						$error("green_led: expected %0d, got %0d", want.green_led, m_tdata[11]);
						fail_count++;
					end
					if (m_tdata[15:12] !== 4'd0) begin
						$error("pad: expected 0, got %0d", m_tdata[15:12]);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_DEBOUNCE_TICKS:   deb_ticks = value[DEB_W-1:0];
			REG_TICKS_PER_SECOND: tps_ticks = value[TPS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_keys.size() != 0 || s_tvalid || expected_leds.size() != 0)
			@(posedge clk);
	endtask

	// mostly press, hold, release sequences; some raw noise
	task automatic queue_random_ticks(int count);
		int                made;
		int                gap;
		int                hold;
		int                pick;
		logic [KEYS_W-1:0] key;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				repeat ($urandom_range(1, 3)) begin
					pending_keys.push_back(KEYS_W'($urandom()));
					made++;
				end
			end else begin
				if (pick < 6)
					key = KEYS_W'(1) << $urandom_range(KEYS_W - 1);
				else
					key = KEYS_W'($urandom_range(1, 65535));
				hold = $urandom_range(1, 4);
				for (int i = 0; i < hold; i++) begin
					// a different key may be down while the first is still held
					if (i > 0 && $urandom_range(3) == 0)
						key = KEYS_W'($urandom_range(1, 65535));
					pending_keys.push_back(key);
					made++;
				end
				gap = $urandom_range(0, (deb_ticks + 2 < 12) ? deb_ticks + 2 : 12);
				if ($urandom_range(9) == 0)
					gap = deb_ticks + 1;
				repeat (gap) begin
					pending_keys.push_back('0);
					made++;
				end
			end
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] deb_val;
		logic [CFG_DATA_W-1:0] tps_val;
		deb_ticks = DEBOUNCE_RESET;
		tps_ticks = TPS_RESET;
		blink_on = 1'b0;
		phase_left = '0;
		rate_now = RATE_RESET;
		holdoff_left = '0;
		key_held = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 76;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: press, frozen hold, press during debounce
		pending_keys = '{16'h0000, 16'h0001, 16'h0001, 16'h0000,
			16'h8000, 16'h8000, 16'h0000, 16'h0000};
		wait_drained();

		// no debounce, shortest period: half period clamps to one
		write_reg(REG_DEBOUNCE_TICKS, 16'd0);
		write_reg(REG_TICKS_PER_SECOND, 16'd2);
		pending_keys = '{16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0F00,
			16'h0000, 16'h0010, 16'h0000, 16'h1000, 16'h1000, 16'h0000,
			16'h0002, 16'h0000, 16'h0000};
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin deb_val = 16'd3;   tps_val = 16'd40;    end
				1: begin deb_val = 16'd255; tps_val = 16'd65535; end
				2: begin deb_val = 16'd1;   tps_val = 16'd2;     end
				3: begin deb_val = 16'd0;   tps_val = 16'd1000;  end
				4: begin deb_val = 16'd7;   tps_val = 16'd17;    end
				5: begin
					deb_val = CFG_DATA_W'($urandom_range(0, 15));
					tps_val = CFG_DATA_W'($urandom_range(2, 200));
				end
				6: begin
					deb_val = CFG_DATA_W'($urandom_range(0, 255));
					tps_val = CFG_DATA_W'($urandom_range(2, 65535));
				end
				default: begin
					deb_val = CFG_DATA_W'($urandom_range(0, 6));
					tps_val = CFG_DATA_W'($urandom_range(2, 64));
				end
			endcase
			if (ph == 2) begin
				send_idle_pct = 76;
				recv_idle_pct = 14;
			end else if (ph == 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(REG_DEBOUNCE_TICKS, deb_val);
			write_reg(REG_TICKS_PER_SECOND, tps_val);
			queue_random_ticks(PHASE_ITEMS);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_leds.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
src/kpblink_pkg.sv
src/kpblink_scan.sv
src/kpblink_div.sv
src/keypad_rate_select_led_blinker_core.sv
tb/sv/keypad_rate_select_led_blinker_core_test.sv
